[design/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge outside reset
`define HKRP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define HKRP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define HKRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/hkrp_pkg.sv]
// types and constants of the keyboard report pacer
// used by the controller, the datapath and the top level
`default_nettype none

package hkrp_pkg;

  localparam int KEY_SLOTS = 6;

  localparam logic [7:0] MOD_FIRST  = 8'hE0;
  localparam logic [7:0] MOD_LAST   = 8'hE7;
  localparam logic [7:0] CTRL_LEFT  = 8'h01;
  localparam logic [7:0] CTRL_RIGHT = 8'h10;
  localparam logic [7:0] GUI_BITS   = 8'h88;
  localparam logic [7:0] GAP_RESET  = 8'd10;

  typedef logic [KEY_SLOTS-1:0][7:0] keys_t;

  typedef struct packed {
    logic [7:0] mods;
    keys_t      keys;
  } snap_t;

  typedef enum logic [2:0] {
    ACT_KEY_DOWN    = 3'd0,
    ACT_KEY_UP      = 3'd1,
    ACT_SYNC_MODS   = 3'd2,
    ACT_RELEASE_ALL = 3'd3,
    ACT_KEEP_ONLY   = 3'd4,
    ACT_DROP        = 3'd5,
    ACT_HOST_LOST   = 3'd6,
    ACT_TICK        = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP_A,
    ST_STEP_B,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic step_a;
    logic step_b;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_b;
  } ctrl_stat_t;

endpackage

`default_nettype wire

[design/hid_keyboard_report_pacer_core.sv]
// top level of the keyboard report pacer
// depends on hkrp_pkg, hkrp_ctrl and hkrp_datapath
//
//   port group | direction | flow control   | payload
//   in_*       | input     | valid / stall  | action, key code, modifiers, keep list, host ready
//   out_*      | output    | valid / stall  | sent flag, report, pending, keys held, stalls
//   cfg_*      | input     | valid / ready  | report gap in ms
//
// an item is taken in the idle state, then takes one ring write step (sync_mods, drop_pending,
// host_lost, tick) or two (key_down, key_up, release_all, keep_only), then a step to load
// the result register; the two steps come from the single ring write port
// the result register lets a new item in while the previous result is stalled; the item
// after that waits in the result load step until the register frees up
// synchronous active-low reset; the ring needs no clearing pass, cfg_ready is always high
`default_nettype none

module hid_keyboard_report_pacer_core
  import hkrp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 128
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [7:0]  in_key_code,
  input  wire logic [7:0]  in_modifier_bits,
  input  wire logic [47:0] in_keep_keys,
  input  wire logic        in_host_ready,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_report_sent,
  output logic [7:0]       out_report_modifiers,
  output logic [47:0]      out_report_keys,
  output logic [7:0]       out_pending_count,
  output logic             out_keys_held,
  output logic [31:0]      out_stall_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_report_gap_ms
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  hkrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  hkrp_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_action            (in_action),
    .in_key_code          (in_key_code),
    .in_modifier_bits     (in_modifier_bits),
    .in_keep_keys         (in_keep_keys),
    .in_host_ready        (in_host_ready),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_report_gap_ms    (cfg_report_gap_ms),
    .out_report_sent      (out_report_sent),
    .out_report_modifiers (out_report_modifiers),
    .out_report_keys      (out_report_keys),
    .out_pending_count    (out_pending_count),
    .out_keys_held        (out_keys_held),
    .out_stall_count      (out_stall_count)
  );

endmodule

`default_nettype wire

[design/hkrp_ctrl.sv]
// controller: item sequencing and result register handshake
// depends on hkrp_pkg
`default_nettype none

module hkrp_ctrl
  import hkrp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire ctrl_stat_t stat,
  output ctrl_cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_STEP_A;
        end
      end
      ST_STEP_A: begin
        cmd.step_a = 1'b1;
        state_nxt  = stat.needs_b ? ST_STEP_B : ST_EMIT;
      end
      ST_STEP_B: begin
        cmd.step_b = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        // wait here until the result register is free
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

`default_nettype wire

[design/hkrp_datapath.sv]
// datapath: keyboard state, snapshot ring memory, pacing and result register
// depends on hkrp_pkg
`default_nettype none

module hkrp_datapath
  import hkrp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 128
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctrl_cmd_t   cmd,
  output ctrl_stat_t       stat,
  input  wire logic [2:0]  in_action,
  input  wire logic [7:0]  in_key_code,
  input  wire logic [7:0]  in_modifier_bits,
  input  wire logic [47:0] in_keep_keys,
  input  wire logic        in_host_ready,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_report_gap_ms,
  output logic             out_report_sent,
  output logic [7:0]       out_report_modifiers,
  output logic [47:0]      out_report_keys,
  output logic [7:0]       out_pending_count,
  output logic             out_keys_held,
  output logic [31:0]      out_stall_count
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

  // latched item
  action_t     act_r;
  logic [7:0]  code_r;
  logic [7:0]  mbits_r;
  keys_t       keep_r;
  logic        ready_r;

  // block state
  snap_t             cur_r, cur_nxt;
  snap_t             last_r, last_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        ela_r, ela_nxt;
  logic              stalled_r, stalled_nxt;
  logic [31:0]       stc_r, stc_nxt;
  logic [7:0]        gap_r;
  snap_t             tgt_r, tgt_nxt;
  logic              go_r, go_nxt;
  logic              sent_r, sent_nxt;
  snap_t             rep_r, rep_nxt;

  // ring memory
  snap_t             mem [QUEUE_DEPTH];
  snap_t             rd_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic              push;

  // helpers
  logic [KEY_SLOTS-1:0] match, free, first_free, listed;
  logic                 code_ok;
  snap_t                keep_tgt, target;
  logic [7:0]           free_ctrl;
  logic                 gui_drop;
  logic [7:0]           ela_inc;
  logic                 due;
  logic                 full;
  logic [SUM_W-1:0]     tail_sum;
  logic [IDX_W-1:0]     tail_idx, prev_head, head_inc;
  logic [CNT_W+7:0]     cnt_ext;

  assign stat.needs_b = (act_r inside {ACT_KEY_DOWN, ACT_KEY_UP, ACT_RELEASE_ALL,
                                       ACT_KEEP_ONLY});

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      match[i] = (cur_r.keys[i] == code_r);
      free[i]  = (cur_r.keys[i] == 8'd0);
    end
  end
  assign first_free = free & ~(free - KEY_SLOTS'(1));
  assign code_ok    = (code_r != 8'd0) && !((code_r >= MOD_FIRST) && (code_r <= MOD_LAST));

  // keep_only target: modifiers masked, keys not in the keep list cleared
  always_comb begin
    keep_tgt      = cur_r;
    keep_tgt.mods = cur_r.mods & mbits_r;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      listed[i] = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        listed[i] = listed[i] | (keep_r[j] == cur_r.keys[i]);
      end
      if (!listed[i]) keep_tgt.keys[i] = 8'd0;
    end
  end
  assign target    = (act_r == ACT_KEEP_ONLY) ? keep_tgt : '0;
  assign free_ctrl = ~cur_r.mods & (CTRL_LEFT | CTRL_RIGHT);
  assign gui_drop  = |(cur_r.mods & ~target.mods & GUI_BITS);

  assign ela_inc = (ela_r == 8'hFF) ? ela_r : ela_r + 8'd1;
  assign due     = (cnt_r != '0) && (ela_inc >= gap_r);

  // ring addressing
  assign full      = (cnt_r == DEPTH_C);
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(cnt_r);
  assign tail_idx  = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);
  assign prev_head = (head_r == '0) ? LAST_IDX : head_r - IDX_W'(1);
  assign head_inc  = (head_r == LAST_IDX) ? '0 : head_r + IDX_W'(1);

  always_comb begin
    cur_nxt     = cur_r;
    last_nxt    = last_r;
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    ela_nxt     = ela_r;
    stalled_nxt = stalled_r;
    stc_nxt     = stc_r;
    tgt_nxt     = tgt_r;
    go_nxt      = go_r;
    sent_nxt    = sent_r;
    rep_nxt     = rep_r;
    push        = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = tail_idx;

    if (cmd.load) begin
      sent_nxt = 1'b0;
      rep_nxt  = '0;
    end

    if (cmd.step_a) begin
      unique case (act_r) inside
        ACT_KEY_DOWN, ACT_SYNC_MODS: begin
          if (cur_r.mods != mbits_r) begin
            cur_nxt.mods = mbits_r;
            push         = 1'b1;
          end
        end
        ACT_KEY_UP: begin
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (match[i]) cur_nxt.keys[i] = 8'd0;
          end
          push = |match;
        end
        ACT_RELEASE_ALL, ACT_KEEP_ONLY: begin
          tgt_nxt = target;
          go_nxt  = (target != cur_r);
          // press a free ctrl before a gui key goes up
          if ((target != cur_r) && gui_drop && (free_ctrl != 8'd0)) begin
            cur_nxt.mods = cur_r.mods | ((free_ctrl & CTRL_LEFT) != 8'd0 ?
                                         CTRL_LEFT : CTRL_RIGHT);
            push         = 1'b1;
          end
        end
        ACT_DROP: begin
          cnt_nxt = '0;
          cur_nxt = last_r;
        end
        ACT_HOST_LOST: begin
          last_nxt = '0;
          push     = (cnt_r == '0) && (cur_r != '0);
        end
        ACT_TICK: begin
          ela_nxt = ela_inc;
          if (due) begin
            if (!ready_r) begin
              if (!stalled_r) stc_nxt = stc_r + 32'd1;
              stalled_nxt = 1'b1;
            end else begin
              stalled_nxt = 1'b0;
              sent_nxt    = 1'b1;
              rep_nxt     = rd_q;
              last_nxt    = rd_q;
              head_nxt    = head_inc;
              cnt_nxt     = cnt_r - CNT_W'(1);
              ela_nxt     = 8'd0;
            end
          end
        end
      endcase
    end

    if (cmd.step_b) begin
      case (act_r) inside
        ACT_KEY_DOWN: begin
          if (code_ok && !(|match) && (|free)) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
              if (first_free[i]) cur_nxt.keys[i] = code_r;
            end
            push = 1'b1;
          end
        end
        ACT_KEY_UP: begin
          if (cur_r.mods != mbits_r) begin
            cur_nxt.mods = mbits_r;
            push         = 1'b1;
          end
        end
        ACT_RELEASE_ALL, ACT_KEEP_ONLY: begin
          if (go_r) begin
            cur_nxt = tgt_r;
            push    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // one snapshot write per cycle; a full ring overwrites the newest entry
    if (push) begin
      mem_we = 1'b1;
      if (full) begin
        mem_wa = prev_head;
      end else begin
        mem_wa  = tail_idx;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= cur_nxt;
    rd_q <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= '0;
      last_r    <= '0;
      head_r    <= '0;
      cnt_r     <= '0;
      ela_r     <= 8'd0;
      stalled_r <= 1'b0;
      stc_r     <= 32'd0;
      gap_r     <= GAP_RESET;
    end else begin
      cur_r     <= cur_nxt;
      last_r    <= last_nxt;
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      ela_r     <= ela_nxt;
      stalled_r <= stalled_nxt;
      stc_r     <= stc_nxt;
      if (cfg_we) gap_r <= cfg_report_gap_ms;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r  <= tgt_nxt;
    go_r   <= go_nxt;
    sent_r <= sent_nxt;
    rep_r  <= rep_nxt;
    if (cmd.load) begin
      act_r   <= action_t'(in_action);
      code_r  <= in_key_code;
      mbits_r <= in_modifier_bits;
      keep_r  <= keys_t'(in_keep_keys);
      ready_r <= in_host_ready;
    end
  end

  assign cnt_ext = {8'd0, cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_report_sent      <= sent_r;
      out_report_modifiers <= rep_r.mods;
      out_report_keys      <= rep_r.keys;
      out_pending_count    <= cnt_ext[7:0];
      out_keys_held        <= (cur_r != '0);
      out_stall_count      <= stc_r;
    end
  end

endmodule

`default_nettype wire

[design/hkrp_checker.sv]
// port-level checks for the keyboard report pacer, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hkrp_checker #(
  parameter int QUEUE_DEPTH = 128
)(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_report_sent,
  input wire logic [7:0]  out_report_modifiers,
  input wire logic [47:0] out_report_keys,
  input wire logic [7:0]  out_pending_count,
  input wire logic [31:0] out_stall_count
);

  // a result with no send carries an empty report
  `HKRP_ASSERT_SAME(a_empty_when_unsent, clk, rst_n,
    out_valid && !out_report_sent,
    out_report_modifiers == 8'd0 && out_report_keys == 48'd0,
    "unsent result carries a report")

  // the queue never reports more entries than it holds
  `HKRP_ASSERT_SAME(a_pending_bound, clk, rst_n,
    out_valid,
    QUEUE_DEPTH > 255 || 32'(out_pending_count) <= 32'(QUEUE_DEPTH),
    "pending count above queue depth")

  // an accepted item keeps the input side busy in the next cycle
  `HKRP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
    in_valid && !in_stall,
    in_stall,
    "input accepted while item in flight")

  // stalled result holds
  `HKRP_ASSERT_NEXT(a_out_hold, clk, rst_n,
    out_valid && out_stall,
    out_valid && $stable(out_report_keys) && $stable(out_pending_count) && $stable(out_stall_count),
    "stalled result changed")

endmodule

bind hid_keyboard_report_pacer_core hkrp_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_hkrp_checker (.*);

`default_nettype wire

[tb/hid_keyboard_report_pacer_core_tb.sv]
// self-checking bench for the keyboard report pacer: random and directed key events,
// predicted report stream checked transfer by transfer
// depends on hkrp_pkg and hid_keyboard_report_pacer_core
module hid_keyboard_report_pacer_core_tb;
  import hkrp_pkg::*;

  localparam int RING_DEPTH = 128;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    action_t     act;
    logic [7:0]  code;
    logic [7:0]  mods;
    logic [47:0] keep;
    logic        ready;
  } kb_event_t;

  typedef struct packed {
    logic        sent;
    logic [7:0]  mods;
    logic [47:0] keys;
    logic [7:0]  pending;
    logic        held;
    logic [31:0] stalls;
  } report_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_action;
  logic [7:0]  in_key_code;
  logic [7:0]  in_modifier_bits;
  logic [47:0] in_keep_keys;
  logic        in_host_ready;
  logic        out_valid;
  logic        out_stall;
  logic        out_report_sent;
  logic [7:0]  out_report_modifiers;
  logic [47:0] out_report_keys;
  logic [7:0]  out_pending_count;
  logic        out_keys_held;
  logic [31:0] out_stall_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_report_gap_ms;

  hid_keyboard_report_pacer_core #(
    .QUEUE_DEPTH(RING_DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_key_code         (in_key_code),
    .in_modifier_bits    (in_modifier_bits),
    .in_keep_keys        (in_keep_keys),
    .in_host_ready       (in_host_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_report_sent     (out_report_sent),
    .out_report_modifiers(out_report_modifiers),
    .out_report_keys     (out_report_keys),
    .out_pending_count   (out_pending_count),
    .out_keys_held       (out_keys_held),
    .out_stall_count     (out_stall_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_report_gap_ms   (cfg_report_gap_ms)
  );

  // stimulus and expectation stores
  kb_event_t pending_events[$];
  report_t   expected_reports[$];
  kb_event_t offered;
  int        send_idle_pct;
  int        stall_pct;
  logic      hold_off;
  event      hold_go;
  int        failures;
  int        cycles;
  logic [7:0] typing_mods;

  // predicted keyboard state
  snap_t       kb_state;
  snap_t       kb_sent;
  snap_t       snap_ring[RING_DEPTH];
  int          ring_rd;
  int          ring_fill;
  logic [7:0]  ms_since_send;
  logic        in_stall_episode;
  logic [31:0] stall_episodes;
  logic [7:0]  gap_ms;

  function automatic void ring_store();
    if (ring_fill >= RING_DEPTH) begin
      // full ring: newest entry is replaced
      snap_ring[(ring_rd + RING_DEPTH - 1) % RING_DEPTH] = kb_state;
    end else begin
      snap_ring[(ring_rd + ring_fill) % RING_DEPTH] = kb_state;
      ring_fill++;
    end
  endfunction

  function automatic void set_modifiers(input logic [7:0] m);
    if (kb_state.mods != m) begin
      kb_state.mods = m;
      ring_store();
    end
  endfunction

  function automatic void release_toward(input snap_t target);
    logic [7:0] free_ctrl;
    if (target != kb_state) begin
      free_ctrl = ~kb_state.mods & (CTRL_LEFT | CTRL_RIGHT);
      // letting go of a gui key: tap a free ctrl first so the host sees no lone gui release
      if ((kb_state.mods & ~target.mods & GUI_BITS) != 8'h00 && free_ctrl != 8'h00) begin
        kb_state.mods = kb_state.mods | (((free_ctrl & CTRL_LEFT) != 8'h00) ? CTRL_LEFT
                                                                             : CTRL_RIGHT);
        ring_store();
      end
      kb_state = target;
      ring_store();
    end
  endfunction

  function automatic report_t pace_event(input kb_event_t ev);
    report_t r;
    snap_t   target;
    logic    hit;
    logic    listed;
    r = '0;
    case (ev.act)
      ACT_KEY_DOWN: begin
        set_modifiers(ev.mods);
        if (ev.code != 8'h00 && !(ev.code >= MOD_FIRST && ev.code <= MOD_LAST)) begin
          hit = 1'b0;
          for (int i = 0; i < KEY_SLOTS; i++)
            if (kb_state.keys[i] == ev.code) hit = 1'b1;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (!hit && kb_state.keys[i] == 8'h00) begin
              kb_state.keys[i] = ev.code;
              ring_store();
              hit = 1'b1;
            end
          end
        end
      end
      ACT_KEY_UP: begin
        // code zero matches every empty slot
        hit = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (kb_state.keys[i] == ev.code) begin
            kb_state.keys[i] = 8'h00;
            hit = 1'b1;
          end
        end
        if (hit) ring_store();
        set_modifiers(ev.mods);
      end
      ACT_SYNC_MODS: set_modifiers(ev.mods);
      ACT_RELEASE_ALL: release_toward('0);
      ACT_KEEP_ONLY: begin
        target = kb_state;
        target.mods = target.mods & ev.mods;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          listed = 1'b0;
          for (int j = 0; j < KEY_SLOTS; j++)
            if (ev.keep[8*j +: 8] == target.keys[i]) listed = 1'b1;
          if (!listed) target.keys[i] = 8'h00;
        end
        release_toward(target);
      end
      ACT_DROP: begin
        ring_fill = 0;
        kb_state = kb_sent;
      end
      ACT_HOST_LOST: begin
        kb_sent = '0;
        if (ring_fill == 0 && kb_state != '0) ring_store();
      end
      default: begin
        if (ms_since_send != 8'hFF) ms_since_send++;
        if (ring_fill != 0 && ms_since_send >= gap_ms) begin
          if (!ev.ready) begin
            if (!in_stall_episode) stall_episodes++;
            in_stall_episode = 1'b1;
          end else begin
            in_stall_episode = 1'b0;
            kb_sent = snap_ring[ring_rd];
            r.sent = 1'b1;
            r.mods = kb_sent.mods;
            r.keys = kb_sent.keys;
            ring_rd = (ring_rd + 1) % RING_DEPTH;
            ring_fill--;
            ms_since_send = 8'h00;
          end
        end
      end
    endcase
    r.pending = ring_fill[7:0];
    r.held = (kb_state != '0);
    r.stalls = stall_episodes;
    return r;
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'h04 + 8'($urandom_range(9));
    if (r < 80) return 8'h00;
    if (r < 90) return MOD_FIRST + 8'($urandom_range(7));
    return 8'($urandom_range(255));
  endfunction

  function automatic kb_event_t random_event(input int tick_pct, input int drop_pct);
    kb_event_t ev;
    int r;
    int s;
    r = $urandom_range(99);
    s = $urandom_range(99);
    if (r < tick_pct) ev.act = ACT_TICK;
    else if (r < tick_pct + drop_pct) ev.act = ACT_DROP;
    else if (s < 45) ev.act = ACT_KEY_DOWN;
    else if (s < 75) ev.act = ACT_KEY_UP;
    else if (s < 85) ev.act = ACT_SYNC_MODS;
    else if (s < 91) ev.act = ACT_KEEP_ONLY;
    else if (s < 95) ev.act = ACT_RELEASE_ALL;
    else ev.act = ACT_HOST_LOST;
    // modifiers mostly stay put while typing
    if ($urandom_range(3) == 0)
      typing_mods = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom_range(255));
    ev.code = pick_code();
    ev.mods = (ev.act == ACT_KEEP_ONLY) ? 8'($urandom_range(255)) : typing_mods;
    if ($urandom_range(3) != 0)
      ev.keep = {pick_code(), pick_code(), pick_code(), pick_code(), pick_code(), pick_code()};
    else
      ev.keep = {16'($urandom()), 32'($urandom())};
    ev.ready = ($urandom_range(99) < 85);
    return ev;
  endfunction

  task automatic queue_event(input action_t a, input logic [7:0] c, input logic [7:0] m,
                             input logic [47:0] k, input logic r);
    kb_event_t ev;
    ev.act = a;
    ev.code = c;
    ev.mods = m;
    ev.keep = k;
    ev.ready = r;
    pending_events.push_back(ev);
  endtask

  task automatic queue_random(input int n, input int tick_pct, input int drop_pct);
    for (int i = 0; i < n; i++) pending_events.push_back(random_event(tick_pct, drop_pct));
  endtask

  task automatic drain();
    while (pending_events.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_gap(input logic [7:0] g);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_report_gap_ms <= g;
    do @(posedge clk); while (!cfg_ready);
    gap_ms = g;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct <= send_pct;
    stall_pct <= recv_pct;
  endtask

  task automatic note_failure(input report_t want, input report_t got, input logic orphan);
    failures++;
    if (failures <= MAX_SHOWN) begin
      if (orphan)
        $display("unexpected transfer: sent=%0d mods=%h keys=%h pending=%0d held=%0d stalls=%0d",
                 got.sent, got.mods, got.keys, got.pending, got.held, got.stalls);
      else
        $display({"mismatch: expected sent=%0d mods=%h keys=%h pending=%0d held=%0d stalls=%0d",
                  " / actual sent=%0d mods=%h keys=%h pending=%0d held=%0d stalls=%0d"},
                 want.sent, want.mods, want.keys, want.pending, want.held, want.stalls,
                 got.sent, got.mods, got.keys, got.pending, got.held, got.stalls);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: next item goes out once the current one is taken
  always @(posedge clk) begin
    kb_event_t next_ev;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_reports.push_back(pace_event(offered));
      if (!in_valid || !in_stall) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_ev = pending_events.pop_front();
          offered <= next_ev;
          in_action <= next_ev.act;
          in_key_code <= next_ev.code;
          in_modifier_bits <= next_ev.mods;
          in_keep_keys <= next_ev.keep;
          in_host_ready <= next_ev.ready;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_report_sent, out_report_modifiers, out_report_keys, out_pending_count,
             out_keys_held, out_stall_count};
      if (expected_reports.size() == 0) begin
        note_failure('0, got, 1'b1);
      end else begin
        want = expected_reports.pop_front();
        if (got.sent !== want.sent || got.mods !== want.mods || got.keys !== want.keys ||
            got.pending !== want.pending || got.held !== want.held ||
            got.stalls !== want.stalls)
          note_failure(want, got, 1'b0);
      end
    end
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    hold_off = 1'b0;
    forever begin
      @(hold_go);
      @(posedge clk);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_TICK;
    in_key_code = 8'h00;
    in_modifier_bits = 8'h00;
    in_keep_keys = '0;
    in_host_ready = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_report_gap_ms = 8'h00;
    offered = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    failures = 0;
    cycles = 0;
    typing_mods = 8'h00;
    kb_state = '0;
    kb_sent = '0;
    ring_rd = 0;
    ring_fill = 0;
    ms_since_send = 8'h00;
    in_stall_episode = 1'b0;
    stall_episodes = '0;
    gap_ms = GAP_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset gap: ticks on an empty ring build up elapsed time
    for (int n = 0; n < 9; n++) queue_event(ACT_TICK, 8'h00, 8'h00, '0, n[0]);
    queue_event(ACT_KEY_DOWN, 8'h04, 8'h00, '0, 1'b1);
    queue_event(ACT_KEY_DOWN, 8'h00, 8'h08, '0, 1'b1);
    queue_event(ACT_KEY_DOWN, 8'hE3, 8'h08, '0, 1'b1);
    queue_event(ACT_KEY_DOWN, 8'h04, 8'h08, '0, 1'b1);
    for (int n = 5; n <= 9; n++) queue_event(ACT_KEY_DOWN, 8'(n), 8'h08, '0, 1'b1);
    queue_event(ACT_KEY_DOWN, 8'h0A, 8'h08, '0, 1'b1);
    queue_event(ACT_KEY_UP, 8'h05, 8'h88, '0, 1'b1);
    queue_event(ACT_KEY_UP, 8'h00, 8'h88, '0, 1'b1);
    queue_event(ACT_SYNC_MODS, 8'h00, 8'h88, '0, 1'b1);
    queue_event(ACT_KEEP_ONLY, 8'h00, 8'h00, 48'h0000_0000_0604, 1'b1);
    queue_event(ACT_KEY_DOWN, 8'hFF, 8'h99, '0, 1'b1);
    queue_event(ACT_RELEASE_ALL, 8'h00, 8'h00, '0, 1'b1);
    queue_event(ACT_KEY_DOWN, 8'h2C, 8'h81, '0, 1'b1);
    queue_event(ACT_RELEASE_ALL, 8'h00, 8'h00, '0, 1'b1);
    queue_event(ACT_TICK, 8'h00, 8'h00, '0, 1'b0);
    queue_event(ACT_TICK, 8'h00, 8'h00, '0, 1'b0);
    queue_event(ACT_TICK, 8'h00, 8'h00, '0, 1'b1);
    queue_event(ACT_HOST_LOST, 8'h00, 8'h00, '0, 1'b1);
    queue_event(ACT_DROP, 8'h00, 8'h00, '0, 1'b1);
    queue_event(ACT_HOST_LOST, 8'h00, 8'h00, '0, 1'b1);
    drain();

    write_gap(8'd0);
    set_idling(0, 0);
    queue_random(250, 30, 3);
    drain();

    // widest gap and no drops: the ring fills and starts overwriting
    write_gap(8'd255);
    set_idling(51, 0);
    queue_random(250, 10, 0);
    drain();

    write_gap(8'd3);
    set_idling(0, 51);
    queue_random(250, 30, 3);
    drain();

    write_gap(8'd1);
    set_idling(14, 14);
    queue_random(200, 25, 3);
    drain();

    write_gap(8'd2);
    set_idling(0, 0);
    -> hold_go;
    queue_random(150, 30, 3);
    drain();

    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/hkrp_pkg.sv
design/hkrp_ctrl.sv
design/hkrp_datapath.sv
design/hid_keyboard_report_pacer_core.sv
design/hkrp_checker.sv
tb/hid_keyboard_report_pacer_core_tb.sv
